### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion on clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/slipv_pkg.sv
// Package for the SLIP receive deframer with IPv4 check.
// Holds SLIP codes, result kinds, error codes and the queue word type.
`default_nettype none
package slipv_pkg;

  localparam int unsigned BufferBytesDefault = 2048;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] SlipEnd    = 8'hC0;
  localparam logic [7:0] SlipEsc    = 8'hDB;
  localparam logic [7:0] SlipEscEnd = 8'hDC;
  localparam logic [7:0] SlipEscEsc = 8'hDD;
  localparam logic [7:0] CharCr     = 8'h0D;

  typedef enum logic [2:0] {
    KIND_FORWARD  = 3'd0,
    KIND_ANNOUNCE = 3'd1,
    KIND_DEBUG    = 3'd2,
    KIND_TEXT     = 3'd3,
    KIND_DROP     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_VERSION = 3'd1,
    ERR_SHORT   = 3'd2,
    ERR_LONG    = 3'd3,
    ERR_HDR     = 3'd4,
    ERR_TCP     = 3'd5,
    ERR_UDP     = 3'd6,
    ERR_ICMP    = 3'd7
  } err_e;

  // One word between the front (deframer) and the back (classifier).
  typedef struct packed {
    logic        is_verdict;
    logic [7:0]  data;
    logic [10:0] length;
    err_e        err;
    logic        announce_ok;
    logic        text_ok;
    logic [7:0]  first_byte;
    logic [31:0] address;
  } qword_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = {1'b0, s[15:0]} + {16'd0, s[16]};
    return t[15:0];
  endfunction

  function automatic logic sensible(input logic [7:0] b);
    return (b == 8'h00) || (b == 8'h0D) || (b == 8'h0A) || (b == 8'h09) ||
           ((b >= 8'h20) && (b <= 8'h7E));
  endfunction

  function automatic logic [7:0] prefix_char(input logic [1:0] i);
    logic [7:0] c;
    unique case (i)
      2'd0: c = 8'h3D;
      2'd1: c = 8'h49;
      2'd2: c = 8'h50;
      default: c = 8'h41;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/slipv_front.sv
// Front part: SLIP unescaping, running sums and the IPv4 frame check.
// Depends on slipv_pkg. Emits queue words for data bytes and frame ends.
`default_nettype none
module slipv_front #(
  parameter int unsigned BufferBytes = slipv_pkg::BufferBytesDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       rx_byte_i,
  output logic                  q_valid_o,
  input  wire logic             q_ready_i,
  output slipv_pkg::qword_t     q_word_o
);
  import slipv_pkg::*;

  localparam int unsigned CntW = $clog2(BufferBytes + 1);

  logic            esc_q;
  logic [CntW-1:0] cnt_q;
  logic [7:0]      first_q;
  logic [15:0]     tot_q;
  logic [7:0]      proto_q;
  logic [15:0]     hsum_q, psum_q, asum_q, udp_q;
  logic [7:0]      odd_q;
  logic            text_q, ann_q;
  logic [31:0]     paddr_q;
  logic            ov_q;
  qword_t          ow_q;

  logic accept, take, close;
  logic [7:0] b;
  logic [CntW-1:0] cnt_inc;
  logic [CntW:0] hl_b;
  logic [CntW-1:0] j;
  logic [15:0] w;
  logic [7:0] first_now;

  assign in_ready_o = !ov_q || q_ready_i;
  assign accept = in_valid_i && in_ready_o;
  assign q_valid_o = ov_q;
  assign q_word_o = ow_q;

  always_comb begin
    b = rx_byte_i;
    take = 1'b0;
    close = 1'b0;
    if (esc_q) begin
      take = 1'b1;
      if (rx_byte_i == SlipEscEnd) b = SlipEnd;
      else if (rx_byte_i == SlipEscEsc) b = SlipEsc;
    end else if (rx_byte_i == SlipEsc) begin
      take = 1'b0;
    end else if (rx_byte_i == SlipEnd) begin
      close = (cnt_q != '0);
    end else begin
      take = 1'b1;
    end
  end

  assign cnt_inc = cnt_q + 1'b1;
  assign first_now = (cnt_q == '0) ? b : first_q;
  assign hl_b = (CntW + 1)'({first_now[3:0], 2'b00});
  assign j = {cnt_q[CntW-1:1], 1'b0};
  assign w = {odd_q, b};

  // Verdict from the running sums at frame end.
  logic [CntW-1:0] n;
  logic [15:0] pay, addr, s0, s1, s2;
  logic [CntW:0] hl;
  err_e err;
  always_comb begin
    n = cnt_q;
    hl = (CntW + 1)'({first_q[3:0], 2'b00});
    pay = psum_q;
    addr = asum_q;
    if (n[0]) begin
      pay = oc_add(psum_q, {odd_q, 8'h00});
      if ((n - 1'b1) >= CntW'(12) && (n - 1'b1) <= CntW'(18))
        addr = oc_add(asum_q, {odd_q, 8'h00});
    end
    s0 = 16'({8'h00, proto_q} + 16'(n) - 16'(hl));
    s1 = oc_add(s0, addr);
    s2 = oc_add(s1, pay);
    if (first_q[7:4] != 4'h4) err = ERR_VERSION;
    else if (32'(tot_q) > 32'(n)) err = ERR_SHORT;
    else if (32'(tot_q) < 32'(n)) err = ERR_LONG;
    else if (32'(hl) > 32'(n)) err = ERR_HDR;
    else if (hsum_q != 16'hFFFF && hsum_q != 16'h0000) err = ERR_HDR;
    else if (proto_q == 8'd6 || proto_q == 8'd17) begin
      if (s2 != 16'hFFFF && s2 != 16'h0000) begin
        if (proto_q == 8'd6) err = ERR_TCP;
        else if (udp_q != 16'h0000) err = ERR_UDP;
        else err = ERR_OK;
      end else err = ERR_OK;
    end else if (proto_q == 8'd1 && pay != 16'hFFFF && pay != 16'h0000) err = ERR_ICMP;
    else err = ERR_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (accept) begin
      ov_q <= take || close;
    end else if (q_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ow_q.is_verdict <= close;
      ow_q.data <= b;
      ow_q.length <= 11'(cnt_q);
      ow_q.err <= err;
      ow_q.announce_ok <= ann_q;
      ow_q.text_ok <= text_q;
      ow_q.first_byte <= first_q;
      ow_q.address <= paddr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
      cnt_q <= '0; first_q <= '0; tot_q <= '0; proto_q <= '0;
      hsum_q <= '0; psum_q <= '0; asum_q <= '0; udp_q <= '0; odd_q <= '0;
      text_q <= 1'b1; ann_q <= 1'b1; paddr_q <= '0;
    end else if (accept) begin
      esc_q <= !esc_q && (rx_byte_i == SlipEsc);
      if (close || (take && cnt_inc == CntW'(BufferBytes))) begin
        cnt_q <= '0; first_q <= '0; tot_q <= '0; proto_q <= '0;
        hsum_q <= '0; psum_q <= '0; asum_q <= '0; udp_q <= '0; odd_q <= '0;
        text_q <= 1'b1; ann_q <= 1'b1; paddr_q <= '0;
      end else if (take) begin
        cnt_q <= cnt_inc;
        first_q <= first_now;
        if (cnt_q != '0 && !sensible(b)) text_q <= 1'b0;
        if (cnt_q < CntW'(4) && b != prefix_char(cnt_q[1:0])) ann_q <= 1'b0;
        if (cnt_q >= CntW'(4) && cnt_q < CntW'(8)) paddr_q <= {paddr_q[23:0], b};
        if (cnt_q == CntW'(2)) tot_q[15:8] <= b;
        if (cnt_q == CntW'(3)) tot_q[7:0] <= b;
        if (cnt_q == CntW'(9)) proto_q <= b;
        if (cnt_q == CntW'(26)) udp_q[15:8] <= b;
        if (cnt_q == CntW'(27)) udp_q[7:0] <= b;
        if (!cnt_q[0]) begin
          odd_q <= b;
        end else begin
          if (32'(j) < 32'(hl_b)) hsum_q <= oc_add(hsum_q, w);
          else psum_q <= oc_add(psum_q, w);
          if (j >= CntW'(12) && j <= CntW'(18)) asum_q <= oc_add(asum_q, w);
        end
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/slipv_queue.sv
// Two-entry queue between the front and the back part.
// Depends on slipv_pkg for the word type.
`default_nettype none
module slipv_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              w_valid_i,
  output logic                   w_ready_o,
  input  wire slipv_pkg::qword_t w_word_i,
  output logic                   r_valid_o,
  input  wire logic              r_ready_i,
  output slipv_pkg::qword_t      r_word_o
);
  import slipv_pkg::*;

  qword_t mem_q [QueueDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign w_ready_o = cnt_q != 2'(QueueDepth);
  assign r_valid_o = cnt_q != 2'd0;
  assign r_word_o = mem_q[rp_q];
  assign push = w_valid_i && w_ready_o;
  assign pop = r_valid_o && r_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= w_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### hw/rtl/slipv_back.sv
// Back part: frame classification, stored address and output register.
// Depends on slipv_pkg.
`default_nettype none
module slipv_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  output logic                   q_ready_o,
  input  wire slipv_pkg::qword_t q_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   is_verdict_o,
  output logic [7:0]             data_byte_o,
  output logic [2:0]             frame_kind_o,
  output logic [2:0]             error_code_o,
  output logic [10:0]            frame_length_o,
  output logic [31:0]            announced_address_o,
  output logic                   address_changed_o
);
  import slipv_pkg::*;

  logic [31:0] last_q;
  logic ov_q;
  logic take, is_ann, chg;
  kind_e kind;

  assign q_ready_o = !ov_q || out_ready_i;
  assign take = q_valid_i && q_ready_o;
  assign out_valid_o = ov_q;

  always_comb begin
    is_ann = (q_word_i.err != ERR_OK) && (q_word_i.length == 11'd8) && q_word_i.announce_ok;
    chg = is_ann && (q_word_i.address != last_q);
    priority if (q_word_i.err == ERR_OK) kind = KIND_FORWARD;
    else if (is_ann) kind = KIND_ANNOUNCE;
    else if (q_word_i.first_byte == CharCr) kind = KIND_DEBUG;
    else if (q_word_i.text_ok) kind = KIND_TEXT;
    else kind = KIND_DROP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; last_q <= '0;
    end else begin
      if (take) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (take && q_word_i.is_verdict && chg) last_q <= q_word_i.address;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      is_verdict_o <= q_word_i.is_verdict;
      if (q_word_i.is_verdict) begin
        data_byte_o <= 8'd0;
        frame_kind_o <= kind;
        error_code_o <= q_word_i.err;
        frame_length_o <= q_word_i.length;
        announced_address_o <= chg ? q_word_i.address : last_q;
        address_changed_o <= chg;
      end else begin
        data_byte_o <= q_word_i.data;
        frame_kind_o <= KIND_FORWARD;
        error_code_o <= ERR_OK;
        frame_length_o <= 11'd0;
        announced_address_o <= 32'd0;
        address_changed_o <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/slip_rx_ipv4_validator.sv
// SLIP receive deframer with an IPv4 header and transport checksum check.
// Input channel: one raw serial byte per word on rx_byte_i (valid/ready).
// Output channel: one word per decoded data byte (is_verdict_o low) and one
// verdict word per non-empty frame, sent when END arrives.
// ESC bytes and empty frames produce no output word.
// Throughput is one input word per cycle unless back-pressure stalls it: the
// front part updates the escape state and all running ones-complement sums.
// From input acceptance a word passes the front register, the two-entry
// queue and the back output register before it reaches the output.
// A stalled receiver first fills the back output register, then the queue,
// then the front register; only then does rx_ready_o drop.
// Reset clears escape state, frame sums, the stored announced address and all
// valid flags; no clearing pass is needed.
// A frame reaching BufferBytes decoded bytes restarts empty with no verdict.
`default_nettype none
module slip_rx_ipv4_validator #(
  parameter int unsigned BufferBytes = slipv_pkg::BufferBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rx_valid_i,
  output logic             rx_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             is_verdict_o,
  output logic [7:0]       data_byte_o,
  output logic [2:0]       frame_kind_o,
  output logic [2:0]       error_code_o,
  output logic [10:0]      frame_length_o,
  output logic [31:0]      announced_address_o,
  output logic             address_changed_o
);
  import slipv_pkg::*;

  // Front to queue and queue to back handshakes.
  logic   f_valid, f_ready, b_valid, b_ready;
  qword_t f_word, b_word;

  slipv_front #(.BufferBytes(BufferBytes)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(rx_valid_i), .in_ready_o(rx_ready_o), .rx_byte_i,
    .q_valid_o(f_valid), .q_ready_i(f_ready), .q_word_o(f_word)
  );

  slipv_queue u_queue (
    .clk_i, .rst_ni,
    .w_valid_i(f_valid), .w_ready_o(f_ready), .w_word_i(f_word),
    .r_valid_o(b_valid), .r_ready_i(b_ready), .r_word_o(b_word)
  );

  slipv_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(b_valid), .q_ready_o(b_ready), .q_word_i(b_word),
    .out_valid_o, .out_ready_i,
    .is_verdict_o, .data_byte_o, .frame_kind_o, .error_code_o,
    .frame_length_o, .announced_address_o, .address_changed_o
  );

endmodule
`default_nettype wire

### hw/rtl/slipv_checker.sv
// Port-level checker for the SLIP receive deframer, bound to the top level.
// Depends on assert_macros.svh and on slipv_pkg for result codes.
`default_nettype none
`include "assert_macros.svh"
module slipv_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        is_verdict_i,
  input wire logic [7:0]  data_byte_i,
  input wire logic [2:0]  frame_kind_i,
  input wire logic [2:0]  error_code_i,
  input wire logic        address_changed_i
);
  import slipv_pkg::*;

  `ASSERT_NEXT(a_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(data_byte_i), "word lost")
  `ASSERT_IMPL(a_ok_fwd, out_valid_i && is_verdict_i && error_code_i == ERR_OK, frame_kind_i == KIND_FORWARD, "ok not fwd")
  `ASSERT_IMPL(a_chg, out_valid_i && address_changed_i, is_verdict_i && frame_kind_i == KIND_ANNOUNCE, "stray change")
  `ASSERT_IMPL(a_data, out_valid_i && !is_verdict_i, frame_kind_i == KIND_FORWARD && error_code_i == ERR_OK, "data fields")
endmodule

bind slip_rx_ipv4_validator slipv_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_i(out_valid_o), .out_ready_i(out_ready_i),
  .is_verdict_i(is_verdict_o), .data_byte_i(data_byte_o), .frame_kind_i(frame_kind_o),
  .error_code_i(error_code_o), .address_changed_i(address_changed_o)
);
`default_nettype wire
